### hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the planar distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tpd_pkg;

	localparam int KIND_WIDTH = 2;
	localparam int DIST_WIDTH = 17;

	// largest representable distance, results above it saturate
	localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

	// distance kinds; the unused code falls back to Euclidean rounded
	typedef enum logic [KIND_WIDTH-1:0] {
		KIND_EUC  = 2'd0,
		KIND_CEIL = 2'd1,
		KIND_ATT  = 2'd2
	} kind_t;

endpackage

`default_nettype wire

### hw/rtl/tpd_cfg_if.sv
// ----------------------------------------------------------------------------
// tpd_cfg_if
// Write channel of the distance kind register.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpd_cfg_if import tpd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [KIND_WIDTH-1:0] distance_kind;

	modport source (output valid, output distance_kind, input ready);
	modport sink (input valid, input distance_kind, output ready);
endinterface

`default_nettype wire

### hw/rtl/tpd_pair_if.sv
// ----------------------------------------------------------------------------
// tpd_pair_if
// Input channel: one pair of points per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpd_pair_if #(
	parameter int COORD_WIDTH = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;

	modport source (
		output valid, output first_x, output first_y, output second_x, output second_y,
		input ready
	);
	modport sink (
		input valid, input first_x, input first_y, input second_x, input second_y,
		output ready
	);
endinterface

`default_nettype wire

### hw/rtl/tpd_dist_if.sv
// ----------------------------------------------------------------------------
// tpd_dist_if
// Output channel: one integer distance per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpd_dist_if import tpd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DIST_WIDTH-1:0] distance;

	modport source (output valid, output distance, input ready);
	modport sink (input valid, input distance, output ready);
endinterface

`default_nettype wire

### hw/rtl/tpd_prep.sv
// ----------------------------------------------------------------------------
// tpd_prep
// Front stages: absolute deltas, squares, then the radicand for the root row.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_prep import tpd_pkg::*; #(
	parameter int COORD_WIDTH = 24,
	parameter int REM_W       = 51
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    adv,
	input  logic                          in_valid,
	input  kind_t                         in_kind,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	output logic [2:0]                    out_valid,
	output kind_t                         out_kind,
	output logic [REM_W-1:0]              out_rem
);

	localparam int SQ_W  = 2 * COORD_WIDTH;
	localparam int SUM_W = SQ_W + 1;

	logic [2:0]             valid_q;
	logic [COORD_WIDTH-1:0] adx_s1, ady_s1;
	kind_t                  kind_s1, kind_s2, kind_s3;
	logic [SQ_W-1:0]        sqx_s2, sqy_s2;
	logic [REM_W-1:0]       rem_s3;

	logic [COORD_WIDTH:0]   dx, dy, mag_x, mag_y;
	logic [SUM_W-1:0]       sum;

	always_comb begin
		dx    = {second_x[COORD_WIDTH-1], second_x} - {first_x[COORD_WIDTH-1], first_x};
		dy    = {second_y[COORD_WIDTH-1], second_y} - {first_y[COORD_WIDTH-1], first_y};
		mag_x = dx[COORD_WIDTH] ? -dx : dx;
		mag_y = dy[COORD_WIDTH] ? -dy : dy;
		sum   = SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) valid_q[0] <= in_valid;
			if (adv[1]) valid_q[1] <= valid_q[0];
			if (adv[2]) valid_q[2] <= valid_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			adx_s1  <= mag_x[COORD_WIDTH-1:0];
			ady_s1  <= mag_y[COORD_WIDTH-1:0];
			kind_s1 <= in_kind;
		end
		if (adv[1] && valid_q[0]) begin
			sqx_s2  <= adx_s1 * adx_s1;
			sqy_s2  <= ady_s1 * ady_s1;
			kind_s2 <= kind_s1;
		end
		if (adv[2] && valid_q[1]) begin
			// rounded Euclidean works on 4*S so the half-unit bit falls out of the root
			rem_s3  <= (kind_s2 == KIND_EUC) ? REM_W'({sum, 2'b00}) : REM_W'(sum);
			kind_s3 <= kind_s2;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_s3;
	assign out_rem   = rem_s3;

endmodule

`default_nettype wire

### hw/rtl/tpd_root_cell.sv
// ----------------------------------------------------------------------------
// tpd_root_cell
// One bit of a digit-by-digit square root: tests k*(r + 2^b)^2 <= T.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_root_cell import tpd_pkg::*; #(
	parameter int ROOT_W  = 26,
	parameter int REM_W   = 51,
	parameter int BIT_POS = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  kind_t             in_kind,
	input  logic [ROOT_W-1:0] in_root,
	input  logic [REM_W-1:0]  in_rem,
	output logic              out_valid,
	output kind_t             out_kind,
	output logic [ROOT_W-1:0] out_root,
	output logic [REM_W-1:0]  out_rem
);

	localparam int TRIAL_W = REM_W + 5;

	logic              valid_s1;
	kind_t             kind_s1;
	logic [ROOT_W-1:0] root_s1;
	logic [REM_W-1:0]  rem_s1;

	logic [TRIAL_W-1:0] trial, trial_k;
	logic               fits;

	// remainder holds T - k*r^2; r has no bits at or below BIT_POS yet,
	// so 2^(b+1)*r + 2^(2b) is a plain OR
	always_comb begin
		trial   = (TRIAL_W'(in_root) << (BIT_POS + 1)) | (TRIAL_W'(1) << (2 * BIT_POS));
		trial_k = (in_kind == KIND_ATT) ? (trial << 3) + (trial << 1) : trial;
		fits    = TRIAL_W'(in_rem) >= trial_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			kind_s1 <= in_kind;
			root_s1 <= fits ? (in_root | (ROOT_W'(1) << BIT_POS)) : in_root;
			rem_s1  <= fits ? (in_rem - trial_k[REM_W-1:0]) : in_rem;
		end
	end

	assign out_valid = valid_s1;
	assign out_kind  = kind_s1;
	assign out_root  = root_s1;
	assign out_rem   = rem_s1;

endmodule

`default_nettype wire

### hw/rtl/tpd_finish.sv
// ----------------------------------------------------------------------------
// tpd_finish
// Output register: ceiling or rounding of the root, scaling to whole units.
// ----------------------------------------------------------------------------
`default_nettype none

module tpd_finish import tpd_pkg::*; #(
	parameter int ROOT_W          = 26,
	parameter int REM_W           = 51,
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  kind_t                 in_kind,
	input  logic [ROOT_W-1:0]     in_root,
	input  logic [REM_W-1:0]      in_rem,
	output logic                  out_valid,
	output logic [DIST_WIDTH-1:0] out_distance
);

	localparam int EXT_W = ROOT_W + COORD_FRAC_BITS + DIST_WIDTH;
	localparam logic [EXT_W-1:0] UNIT = {{(EXT_W-1){1'b0}}, 1'b1} << COORD_FRAC_BITS;

	logic                  valid_s1;
	logic [DIST_WIDTH-1:0] distance_s1;

	logic [EXT_W-1:0] sum, scaled;
	logic [DIST_WIDTH-1:0] dist_sat;

	always_comb begin
		case (in_kind)
			KIND_CEIL, KIND_ATT: begin
				// nonzero remainder: root was not exact, step up to the ceiling
				sum    = EXT_W'(in_root) + EXT_W'(in_rem != '0) + (UNIT - EXT_W'(1));
				scaled = sum >> COORD_FRAC_BITS;
			end
			default: begin
				sum    = EXT_W'(in_root) + UNIT;
				scaled = sum >> (COORD_FRAC_BITS + 1);
			end
		endcase
		dist_sat = (scaled > EXT_W'(DIST_MAX)) ? DIST_MAX : scaled[DIST_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			distance_s1 <= dist_sat;
		end
	end

	assign out_valid    = valid_s1;
	assign out_distance = distance_s1;

endmodule

`default_nettype wire

### hw/rtl/tsplib_planar_distance.sv
// ----------------------------------------------------------------------------
// tsplib_planar_distance
// Integer TSPLIB distance (EUC_2D, CEIL_2D, ATT) between two fixed-point points.
// Throughput: one pair per cycle while the pipeline has room; three front stages,
// one root cell per result bit (COORD_WIDTH+2 cells), one output register. Each
// stage advances on its own, so bubbles collapse and input keeps flowing while a
// result waits, until every stage holds an item.
// Reset clears all stage valids and sets the kind register to EUC_2D.
// ----------------------------------------------------------------------------
`default_nettype none

module tsplib_planar_distance import tpd_pkg::*; #(
	parameter int COORD_WIDTH     = 24,
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	tpd_cfg_if.sink     cfg,
	tpd_pair_if.sink    pair,
	tpd_dist_if.source  result
);

	localparam int ROOT_W = COORD_WIDTH + 2;
	localparam int REM_W  = 2 * COORD_WIDTH + 3;
	localparam int NS     = ROOT_W + 4;

	logic [KIND_WIDTH-1:0] distance_kind_q;
	kind_t                 kind;

	logic [NS-1:0] stg_v;
	logic [NS-1:0] adv;

	logic [2:0]        prep_v;
	logic              fin_v;
	logic              cell_v    [0:ROOT_W];
	kind_t             cell_kind [0:ROOT_W];
	logic [ROOT_W-1:0] cell_root [0:ROOT_W];
	logic [REM_W-1:0]  cell_rem  [0:ROOT_W];

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_kind_q <= KIND_WIDTH'(KIND_EUC);
		end else if (cfg.valid) begin
			distance_kind_q <= cfg.distance_kind;
		end
	end

	always_comb begin
		case (kind_t'(distance_kind_q))
			KIND_CEIL: kind = KIND_CEIL;
			KIND_ATT:  kind = KIND_ATT;
			default:   kind = KIND_EUC;
		endcase
	end

	// stage advance: a stage moves when empty or when the one after it moves
	always_comb begin
		stg_v[2:0]  = prep_v;
		for (int i = 0; i < ROOT_W; i++) begin
			stg_v[3 + i] = cell_v[i + 1];
		end
		stg_v[NS-1] = fin_v;
	end

	always_comb begin
		adv[NS-1] = !stg_v[NS-1] || result.ready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = !stg_v[i] || adv[i + 1];
		end
	end

	assign pair.ready = adv[0];

	tpd_prep #(
		.COORD_WIDTH (COORD_WIDTH),
		.REM_W       (REM_W)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv[2:0]),
		.in_valid  (pair.valid),
		.in_kind   (kind),
		.first_x   (pair.first_x),
		.first_y   (pair.first_y),
		.second_x  (pair.second_x),
		.second_y  (pair.second_y),
		.out_valid (prep_v),
		.out_kind  (cell_kind[0]),
		.out_rem   (cell_rem[0])
	);

	assign cell_v[0]    = prep_v[2];
	assign cell_root[0] = '0;

	// root row, most significant bit first
	for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
		tpd_root_cell #(
			.ROOT_W  (ROOT_W),
			.REM_W   (REM_W),
			.BIT_POS (ROOT_W - 1 - g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv[3 + g]),
			.in_valid  (cell_v[g]),
			.in_kind   (cell_kind[g]),
			.in_root   (cell_root[g]),
			.in_rem    (cell_rem[g]),
			.out_valid (cell_v[g + 1]),
			.out_kind  (cell_kind[g + 1]),
			.out_root  (cell_root[g + 1]),
			.out_rem   (cell_rem[g + 1])
		);
	end

	tpd_finish #(
		.ROOT_W          (ROOT_W),
		.REM_W           (REM_W),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv[NS-1]),
		.in_valid     (cell_v[ROOT_W]),
		.in_kind      (cell_kind[ROOT_W]),
		.in_root      (cell_root[ROOT_W]),
		.in_rem       (cell_rem[ROOT_W]),
		.out_valid    (fin_v),
		.out_distance (result.distance)
	);

	assign result.valid = fin_v;

	// an accepting sink downstream leaves no stage stalled
	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> pair.ready)
		else $error("input stalled while output sink is ready");

	// an empty output register never backs up the pipeline
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> pair.ready)
		else $error("input stalled with no result pending");

	// a new result comes only from the last root cell
	a_result_from_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(stg_v[NS-2]))
		else $error("result appeared without an item in the last cell");

endmodule

`default_nettype wire
